>>> hw/rtl/akl_pkg.sv
// ----------------------------------------------------------------------------
// akl_pkg: shared types and functions for the AES key ladder
// Holds the S-box tables and the GF(2^8) helpers used by the round unit.
// ----------------------------------------------------------------------------
package akl_pkg;

	typedef logic [127:0] blk_t;

	function automatic logic [7:0] xt(input logic [7:0] a);
		xt = a[7] ? ((a << 1) ^ 8'h1b) : (a << 1);
	endfunction

	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		logic [7:0] x;
		p = 8'h00;
		x = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) p = p ^ x;
			x = xt(x);
		end
		gmul = p;
	endfunction

	function automatic logic [7:0] ginv(input logic [7:0] x);
		logic [7:0] r;
		logic [7:0] b;
		r = 8'h01;
		b = x;
		for (int i = 0; i < 8; i++) begin
			if (i != 0) r = gmul(r, b);
			b = gmul(b, b);
		end
		ginv = r;
	endfunction

	function automatic logic [7:0] rl(input logic [7:0] v, input int n);
		rl = (v << n) | (v >> (8 - n));
	endfunction

	function automatic logic [7:0] sbox(input logic [7:0] x);
		logic [7:0] b;
		b = ginv(x);
		sbox = b ^ rl(b, 1) ^ rl(b, 2) ^ rl(b, 3) ^ rl(b, 4) ^ 8'h63;
	endfunction

	function automatic logic [7:0] isbox(input logic [7:0] y);
		isbox = ginv(rl(y, 1) ^ rl(y, 3) ^ rl(y, 6) ^ 8'h05);
	endfunction

	typedef logic [7:0] sb_arr_t [256];

	function automatic sb_arr_t mk_sbox(input logic inv);
		sb_arr_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = inv ? isbox(8'(i)) : sbox(8'(i));
		end
		mk_sbox = t;
	endfunction

	localparam sb_arr_t SBOX  = mk_sbox(1'b0);
	localparam sb_arr_t ISBOX = mk_sbox(1'b1);

	function automatic logic [7:0] byte_of(input blk_t v, input int i);
		byte_of = v[127 - 8 * i -: 8];
	endfunction

endpackage

>>> hw/rtl/akl_round.sv
// ----------------------------------------------------------------------------
// akl_round: one AES decryption round and one key-schedule step
// Combinational; the sequencer registers the state and round key.
// ----------------------------------------------------------------------------
module akl_round import akl_pkg::*; (
	input  blk_t       state,
	input  blk_t       rkey,
	input  logic       last,
	input  logic [7:0] rcon,
	output blk_t       state_nxt,
	output blk_t       rkey_nxt
);

	blk_t sr;
	blk_t ak;
	blk_t mx;
	logic [31:0] t;

	// Inverse shift rows plus inverse S-box, then add key, then inverse mix (skipped when last is set).
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				sr[127 - 8 * (c * 4 + r) -: 8] =
					ISBOX[byte_of(state, ((c - r) & 3) * 4 + r)];
			end
		end
		ak = sr ^ rkey;
		for (int c = 0; c < 4; c++) begin
			logic [7:0] a0, a1, a2, a3;
			a0 = byte_of(ak, c * 4);
			a1 = byte_of(ak, c * 4 + 1);
			a2 = byte_of(ak, c * 4 + 2);
			a3 = byte_of(ak, c * 4 + 3);
			mx[127 - 32 * c -: 8] = gmul(a0, 8'd14) ^ gmul(a1, 8'd11) ^ gmul(a2, 8'd13)
				^ gmul(a3, 8'd9);
			mx[119 - 32 * c -: 8] = gmul(a0, 8'd9) ^ gmul(a1, 8'd14) ^ gmul(a2, 8'd11)
				^ gmul(a3, 8'd13);
			mx[111 - 32 * c -: 8] = gmul(a0, 8'd13) ^ gmul(a1, 8'd9) ^ gmul(a2, 8'd14)
				^ gmul(a3, 8'd11);
			mx[103 - 32 * c -: 8] = gmul(a0, 8'd11) ^ gmul(a1, 8'd13) ^ gmul(a2, 8'd9)
				^ gmul(a3, 8'd14);
		end
		state_nxt = last ? ak : mx;
	end

	// Forward key schedule step: the next round key from the current one.
	always_comb begin
		t = {SBOX[rkey[23:16]] ^ rcon, SBOX[rkey[15:8]], SBOX[rkey[7:0]], SBOX[rkey[31:24]]};
		rkey_nxt[127:96] = rkey[127:96] ^ t;
		rkey_nxt[95:64]  = rkey[95:64] ^ rkey_nxt[127:96];
		rkey_nxt[63:32]  = rkey[63:32] ^ rkey_nxt[95:64];
		rkey_nxt[31:0]   = rkey[31:0] ^ rkey_nxt[63:32];
	end

endmodule

>>> hw/rtl/aes_key_ladder_derivation.sv
// ----------------------------------------------------------------------------
// aes_key_ladder_derivation: three-stage AES-128 key ladder
// Decrypts the kek seed, the source and, unless it is zero, the key seed in
// turn with one shared round unit.
// ----------------------------------------------------------------------------
// Usage: drive the eight 64-bit inputs and pulse start while busy is low;
// that edge accepts the transaction and busy rises at once. Each AES
// decryption runs on one shared round unit: forward key expansion to
// reach the last round key, then 10 inverse rounds that walk the
// schedule backwards, one round per cycle. Two decryptions run when the
// key seed is zero and three otherwise, and done is strobed after the
// last one. The result sits on derived_hi/derived_lo from the cycle that
// done is high until the next start is taken; the receiver cannot stall,
// and busy falls in that cycle so a new start can be taken at the edge
// that ends it.
// Reset clears the sequencer; the data registers need no reset.
// The round key used at inverse round r is recovered from round key r+1
// by the inverse schedule step, so no key table is stored.
// ----------------------------------------------------------------------------
module aes_key_ladder_derivation import akl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] source_hi,
	input  logic [63:0] source_lo,
	input  logic [63:0] master_hi,
	input  logic [63:0] master_lo,
	input  logic [63:0] kek_seed_hi,
	input  logic [63:0] kek_seed_lo,
	input  logic [63:0] key_seed_hi,
	input  logic [63:0] key_seed_lo,
	output logic        done,
	output logic [63:0] derived_hi,
	output logic [63:0] derived_lo
);

	typedef enum logic [1:0] {ST_IDLE, ST_EXP, ST_DEC} st_t;

	st_t        st_q;
	logic [1:0] pass_q;
	logic [3:0] cnt_q;
	logic [7:0] rcon_q;
	blk_t       st_blk_q;
	blk_t       key_q;
	blk_t       src_q;
	blk_t       seed_q;
	logic       skip_q;
	logic       done_q;

	blk_t state_nxt;
	blk_t rkey_fwd;
	blk_t rkey_bwd;
	logic [31:0] tb;

	// The round unit's key path is used forward during expansion. During
	// decryption the current key is the one just consumed, stepped back.
	akl_round u_round (
		.state     (st_blk_q),
		.rkey      (rkey_bwd),
		.last      (cnt_q == 4'd1),
		.rcon      (rcon_q),
		.state_nxt (state_nxt),
		.rkey_nxt  (rkey_fwd)
	);

	// Inverse key step: key r from key r+1, with rcon of step r+1; key_q as is during expansion.
	always_comb begin
		rkey_bwd[31:0]   = key_q[31:0] ^ key_q[63:32];
		rkey_bwd[63:32]  = key_q[63:32] ^ key_q[95:64];
		rkey_bwd[95:64]  = key_q[95:64] ^ key_q[127:96];
		tb = {SBOX[rkey_bwd[23:16]] ^ rcon_q, SBOX[rkey_bwd[15:8]], SBOX[rkey_bwd[7:0]],
			SBOX[rkey_bwd[31:24]]};
		rkey_bwd[127:96] = key_q[127:96] ^ tb;
		if (st_q == ST_EXP) rkey_bwd = key_q;
	end

	function automatic logic [7:0] rcon_back(input logic [7:0] r);
		rcon_back = r[0] ? {1'b1, r[7:1] ^ 7'h0d} : {1'b0, r[7:1]};
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			pass_q <= 2'd0;
			cnt_q  <= 4'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (start) begin
						key_q  <= {master_hi, master_lo};
						src_q  <= {source_hi, source_lo};
						seed_q <= {key_seed_hi, key_seed_lo};
						skip_q <= ({key_seed_hi, key_seed_lo} == '0);
						st_blk_q <= {kek_seed_hi, kek_seed_lo};
						rcon_q <= 8'h01;
						cnt_q  <= 4'd10;
						pass_q <= 2'd0;
						st_q   <= ST_EXP;
					end
				end
				ST_EXP: begin
					key_q <= rkey_fwd;
					cnt_q <= cnt_q - 4'd1;
					if (cnt_q == 4'd1) begin
						// rcon_q now holds the constant of step 10.
						st_blk_q <= st_blk_q ^ rkey_fwd;
						cnt_q    <= 4'd10;
						st_q     <= ST_DEC;
					end else begin
						rcon_q <= xt(rcon_q);
					end
				end
				ST_DEC: begin
					st_blk_q <= state_nxt;
					key_q    <= rkey_bwd;
					rcon_q   <= rcon_back(rcon_q);
					cnt_q    <= cnt_q - 4'd1;
					if (cnt_q == 4'd1) begin
						if (pass_q == 2'd2 || (pass_q == 2'd1 && skip_q)) begin
							done_q <= 1'b1;
							st_blk_q <= state_nxt;
							st_q <= ST_IDLE;
						end else begin
							key_q    <= state_nxt;
							st_blk_q <= (pass_q == 2'd0) ? src_q : seed_q;
							rcon_q   <= 8'h01;
							cnt_q    <= 4'd10;
							pass_q   <= pass_q + 2'd1;
							st_q     <= ST_EXP;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign busy       = (st_q != ST_IDLE);
	assign done       = done_q;
	assign derived_hi = st_blk_q[127:64];
	assign derived_lo = st_blk_q[63:0];

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("start not taken");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (cnt_q != 4'd0 && cnt_q <= 4'd10)) else $error("round count");
	a_pass_range: assert property (@(posedge clk) disable iff (!arst_n)
		pass_q != 2'd3) else $error("pass count");
`endif

endmodule

>>> tb/akl_ladder_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// akl_ladder_checker: derived key predictor and comparator
// Watches the start/busy and done channels of the key ladder. It predicts
// each derived key with its own AES-128 decryption and compares the strobed
// result with the oldest pending prediction.
// ----------------------------------------------------------------------------
module akl_ladder_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [63:0] source_hi,
	input  logic [63:0] source_lo,
	input  logic [63:0] master_hi,
	input  logic [63:0] master_lo,
	input  logic [63:0] kek_seed_hi,
	input  logic [63:0] kek_seed_lo,
	input  logic [63:0] key_seed_hi,
	input  logic [63:0] key_seed_lo,
	input  logic        done,
	input  logic [63:0] derived_hi,
	input  logic [63:0] derived_lo,
	output int          mismatch_count,
	output int          pending_keys
);

	logic [7:0]   fwd_sub [256];
	logic [7:0]   inv_sub [256];
	logic [127:0] expected_keys [$];

	function automatic logic [7:0] gf_mult(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) p = p ^ a;
			a = a[7] ? ((a << 1) ^ 8'h1b) : (a << 1);
		end
		return p;
	endfunction

	function automatic logic [7:0] rot8(input logic [7:0] v, input int n);
		return (v << n) | (v >> (8 - n));
	endfunction

	// Substitution tables built from the field inverse (x^254) and the affine map.
	initial begin
		logic [7:0] inv, sq, s;
		for (int x = 0; x < 256; x++) begin
			inv = 8'h01;
			sq = 8'(x);
			for (int e = 0; e < 8; e++) begin
				if (e != 0) inv = gf_mult(inv, sq);
				sq = gf_mult(sq, sq);
			end
			s = inv ^ rot8(inv, 1) ^ rot8(inv, 2) ^ rot8(inv, 3) ^ rot8(inv, 4) ^ 8'h63;
			fwd_sub[x] = s;
			inv_sub[s] = 8'(x);
		end
	end

	function automatic logic [127:0] aes128_decrypt(input logic [127:0] key,
			input logic [127:0] blk);
		logic [31:0]  w [44];
		logic [31:0]  t;
		logic [7:0]   rcon;
		logic [7:0]   s [16];
		logic [7:0]   o [16];
		logic [7:0]   a0, a1, a2, a3;
		logic [127:0] rk;
		logic [127:0] res;
		rcon = 8'h01;
		for (int i = 0; i < 4; i++) w[i] = key[127 - 32 * i -: 32];
		for (int i = 4; i < 44; i++) begin
			t = w[i - 1];
			if (i % 4 == 0) begin
				t = {t[23:0], t[31:24]};
				t = {fwd_sub[t[31:24]], fwd_sub[t[23:16]], fwd_sub[t[15:8]], fwd_sub[t[7:0]]};
				t[31:24] = t[31:24] ^ rcon;
				rcon = gf_mult(rcon, 8'h02);
			end
			w[i] = w[i - 4] ^ t;
		end
		for (int i = 0; i < 16; i++) s[i] = blk[127 - 8 * i -: 8];
		for (int r = 10; r >= 0; r--) begin
			if (r != 10) begin
				// Inverse row shift folded into the inverse substitution.
				o = s;
				for (int c = 0; c < 4; c++)
					for (int j = 0; j < 4; j++)
						s[c * 4 + j] = inv_sub[o[((c - j) & 3) * 4 + j]];
			end
			rk = {w[4 * r], w[4 * r + 1], w[4 * r + 2], w[4 * r + 3]};
			for (int i = 0; i < 16; i++) s[i] = s[i] ^ rk[127 - 8 * i -: 8];
			if (r != 10 && r != 0) begin
				for (int c = 0; c < 4; c++) begin
					a0 = s[c * 4];
					a1 = s[c * 4 + 1];
					a2 = s[c * 4 + 2];
					a3 = s[c * 4 + 3];
					s[c * 4]     = gf_mult(a0, 14) ^ gf_mult(a1, 11) ^ gf_mult(a2, 13) ^ gf_mult(a3, 9);
					s[c * 4 + 1] = gf_mult(a0, 9) ^ gf_mult(a1, 14) ^ gf_mult(a2, 11) ^ gf_mult(a3, 13);
					s[c * 4 + 2] = gf_mult(a0, 13) ^ gf_mult(a1, 9) ^ gf_mult(a2, 14) ^ gf_mult(a3, 11);
					s[c * 4 + 3] = gf_mult(a0, 11) ^ gf_mult(a1, 13) ^ gf_mult(a2, 9) ^ gf_mult(a3, 14);
				end
			end
		end
		for (int i = 0; i < 16; i++) res[127 - 8 * i -: 8] = s[i];
		return res;
	endfunction

	function automatic logic [127:0] ladder_key(input logic [127:0] src,
			input logic [127:0] master, input logic [127:0] kek_seed,
			input logic [127:0] key_seed);
		logic [127:0] kek;
		logic [127:0] src_kek;
		kek = aes128_decrypt(master, kek_seed);
		src_kek = aes128_decrypt(kek, src);
		if (key_seed == '0) return src_kek;
		return aes128_decrypt(src_kek, key_seed);
	endfunction

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		mismatch_count++;
	endtask

	initial begin
		mismatch_count = 0;
		pending_keys = 0;
	end

	always @(posedge clk) begin
		logic [127:0] want;
		if (arst_n) begin
			if (done) begin
				if (expected_keys.size() == 0) begin
					report_mismatch($sformatf("unexpected result %h_%h", derived_hi, derived_lo));
				end else begin
					want = expected_keys.pop_front();
					if (derived_hi !== want[127:64])
						report_mismatch($sformatf("derived_hi %h, expected %h",
							derived_hi, want[127:64]));
					if (derived_lo !== want[63:0])
						report_mismatch($sformatf("derived_lo %h, expected %h",
							derived_lo, want[63:0]));
				end
			end
			if (start && !busy)
				expected_keys.push_back(ladder_key({source_hi, source_lo},
					{master_hi, master_lo}, {kek_seed_hi, kek_seed_lo},
					{key_seed_hi, key_seed_lo}));
			pending_keys = expected_keys.size();
		end
	end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: regression for the AES key ladder
// Drives directed and random derivation requests in bursts with gaps and
// lets the checker predict and compare every derived key.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int RANDOM_TRANSACTIONS = 2000;
	// Cycles to run on after the last pending key has been checked.
	localparam int DRAIN_CYCLES = 80;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [63:0] source_hi, source_lo;
	logic [63:0] master_hi, master_lo;
	logic [63:0] kek_seed_hi, kek_seed_lo;
	logic [63:0] key_seed_hi, key_seed_lo;
	logic        done;
	logic [63:0] derived_hi, derived_lo;
	int          mismatch_count;
	int          pending_keys;

	aes_key_ladder_derivation u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.source_hi  (source_hi),
		.source_lo  (source_lo),
		.master_hi  (master_hi),
		.master_lo  (master_lo),
		.kek_seed_hi(kek_seed_hi),
		.kek_seed_lo(kek_seed_lo),
		.key_seed_hi(key_seed_hi),
		.key_seed_lo(key_seed_lo),
		.done       (done),
		.derived_hi (derived_hi),
		.derived_lo (derived_lo)
	);

	akl_ladder_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.source_hi     (source_hi),
		.source_lo     (source_lo),
		.master_hi     (master_hi),
		.master_lo     (master_lo),
		.kek_seed_hi   (kek_seed_hi),
		.kek_seed_lo   (kek_seed_lo),
		.key_seed_hi   (key_seed_hi),
		.key_seed_lo   (key_seed_lo),
		.done          (done),
		.derived_hi    (derived_hi),
		.derived_lo    (derived_lo),
		.mismatch_count(mismatch_count),
		.pending_keys  (pending_keys)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Presents one derivation request and holds it until the edge that takes
	// it, which is the first edge at which busy is seen low. Start is left
	// high so that a following request in the same burst is back to back.
	task automatic send_derivation(input logic [63:0] src_h, input logic [63:0] src_l,
			input logic [63:0] mst_h, input logic [63:0] mst_l,
			input logic [63:0] kek_h, input logic [63:0] kek_l,
			input logic [63:0] seed_h, input logic [63:0] seed_l);
		start       <= 1'b1;
		source_hi   <= src_h;
		source_lo   <= src_l;
		master_hi   <= mst_h;
		master_lo   <= mst_l;
		kek_seed_hi <= kek_h;
		kek_seed_lo <= kek_l;
		key_seed_hi <= seed_h;
		key_seed_lo <= seed_l;
		do @(posedge clk); while (busy);
	endtask

	// Idle for a number of cycles; source_hi and master_lo carry noise meanwhile,
	// which the block must ignore since start is low.
	task automatic idle_gap(input int cycles);
		for (int i = 0; i < cycles; i++) begin
			start     <= 1'b0;
			source_hi <= rand64();
			master_lo <= rand64();
			@(posedge clk);
		end
	endtask

	// Random request. The key seed is zero about a quarter of the time, so the
	// short two-step path is well covered, and sometimes only one half is zero.
	task automatic send_random();
		logic [63:0] seed_h, seed_l;
		int sel;
		sel = $urandom_range(0, 7);
		seed_h = rand64();
		seed_l = rand64();
		if (sel < 2) begin
			seed_h = '0;
			seed_l = '0;
		end else if (sel == 2) begin
			seed_h = '0;
		end else if (sel == 3) begin
			seed_l = '0;
		end
		send_derivation(rand64(), rand64(), rand64(), rand64(), rand64(), rand64(),
			seed_h, seed_l);
	endtask

	initial begin
		int sent;
		int burst;
		start       <= 1'b0;
		source_hi   <= '0;
		source_lo   <= '0;
		master_hi   <= '0;
		master_lo   <= '0;
		kek_seed_hi <= '0;
		kek_seed_lo <= '0;
		key_seed_hi <= '0;
		key_seed_lo <= '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: all-zero and all-one values, a zero key seed on its
		// own, key seeds with only one half zero, and a lone bit at each end.
		send_derivation('0, '0, '0, '0, '0, '0, '0, '0);
		send_derivation('1, '1, '1, '1, '1, '1, '1, '1);
		send_derivation('1, '1, '1, '1, '1, '1, '0, '0);
		send_derivation('0, '0, '0, '0, '0, '0, '1, '1);
		send_derivation(rand64(), rand64(), rand64(), rand64(), rand64(), rand64(), '0, '0);
		send_derivation(rand64(), rand64(), rand64(), rand64(), rand64(), rand64(),
			'0, 64'h1);
		send_derivation(rand64(), rand64(), rand64(), rand64(), rand64(), rand64(),
			64'h8000_0000_0000_0000, '0);
		idle_gap(3);
		send_derivation(64'h8000_0000_0000_0000, 64'h1, 64'h8000_0000_0000_0000, 64'h1,
			64'h8000_0000_0000_0000, 64'h1, 64'h8000_0000_0000_0000, 64'h1);
		send_derivation(64'h1, 64'h8000_0000_0000_0000, 64'h1, 64'h8000_0000_0000_0000,
			64'h1, 64'h8000_0000_0000_0000, 64'h1, 64'h8000_0000_0000_0000);
		send_derivation(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff,
			64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f,
			64'h69c4_e0d8_6a7b_0430, 64'hd8cd_b780_70b4_c55a, '0, '0);
		idle_gap(1);

		// Random part: bursts of random length; some gaps are empty so that
		// long back-to-back stretches occur as well.
		sent = 0;
		while (sent < RANDOM_TRANSACTIONS) begin
			burst = $urandom_range(1, 12);
			for (int i = 0; i < burst && sent < RANDOM_TRANSACTIONS; i++) begin
				send_random();
				sent++;
			end
			idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 70));
		end
		start <= 1'b0;

		while (pending_keys != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && pending_keys == 0) begin
			$display("aes_key_ladder_derivation regression: pass");
		end else begin
			$display("aes_key_ladder_derivation regression: fail");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run (about 2000 transactions plus
	// the idle gaps between bursts).
	initial begin
		#2_000_000;
		$display("aes_key_ladder_derivation regression: fail");
		$finish;
	end

endmodule
